/* hw/rtl/vfm_pkg.sv */
// Package for the voxel visible-face mask block.
// Holds grid geometry constants, command and face codes, and the bank write request type.
// No dependencies.
package vfm_pkg;

  localparam int GRID_EDGE = 64;
  localparam int COORD_W   = 6;
  localparam int ROW_W     = 1 << COORD_W;
  localparam int BANK_AW   = 2 * COORD_W - 1;
  localparam int BANK_ROWS = 1 << BANK_AW;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_t;

  localparam int FACE_NEG_Z = 0;
  localparam int FACE_NEG_X = 1;
  localparam int FACE_POS_Z = 2;
  localparam int FACE_POS_X = 3;
  localparam int FACE_POS_Y = 4;
  localparam int FACE_NEG_Y = 5;

  typedef struct packed {
    logic               en;
    logic [BANK_AW-1:0] addr;
    logic [ROW_W-1:0]   data;
  } vfm_wr_t;

endpackage

/* hw/rtl/vfm_bank.sv */
// One occupancy bank: z-rows for cells of one x parity, addressed by {x/2, y}.
// One write port, two registered read ports. Depends on vfm_pkg.
module vfm_bank (
  input  logic                    clk,
  input  vfm_pkg::vfm_wr_t        wr,
  input  logic [vfm_pkg::BANK_AW-1:0] rd_addr0,
  input  logic [vfm_pkg::BANK_AW-1:0] rd_addr1,
  output logic [vfm_pkg::ROW_W-1:0]   rd_data0,
  output logic [vfm_pkg::ROW_W-1:0]   rd_data1
);
  import vfm_pkg::*;

  logic [ROW_W-1:0] mem [BANK_ROWS];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data0 <= mem[rd_addr0];
    rd_data1 <= mem[rd_addr1];
  end

endmodule

/* hw/rtl/voxel_visible_face_mask_top.sv */
// Top level of the voxel visible-face mask block: occupancy grid in two banks,
// write and query sequencer, output register. Depends on vfm_pkg and vfm_bank.
//
// The grid is stored as 64-bit z-rows in two banks split by x parity, so a
// query reads its own row and the y neighbors from one bank and the x neighbors
// from the other. After reset a clearing pass zeroes both banks, during which
// no request is taken. A write request reads the row, then writes back the
// modified row in S_WR. A query passes through S_QB and S_QC, since the bank that
// holds the queried cell must deliver three rows over its two read ports. The
// result sits in an output register; a query waits in its last cycle only while
// an earlier result has not been taken.
module voxel_visible_face_mask_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        cmd,
  input  logic [vfm_pkg::COORD_W-1:0] pos_x,
  input  logic [vfm_pkg::COORD_W-1:0] pos_y,
  input  logic [vfm_pkg::COORD_W-1:0] pos_z,
  input  logic                        solid_in,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [5:0]                  face_mask,
  output logic [2:0]                  face_count,
  output logic                        cell_solid
);
  import vfm_pkg::*;

  localparam logic [COORD_W:0]   EDGE_C = (COORD_W + 1)'(GRID_EDGE);
  localparam logic [COORD_W-1:0] LAST_C = COORD_W'(GRID_EDGE - 1);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_WR    = 5'b00100,
    S_QB    = 5'b01000,
    S_QC    = 5'b10000
  } state_t;

  state_t state, state_next;

  logic [BANK_AW-1:0] clr_addr;
  logic [COORD_W-1:0] x_q, y_q, z_q;
  logic               solid_q, inside_q;
  logic               solid_c, nb_zm, nb_zp, nb_xm, nb_xp, nb_ym, nb_yp;

  logic               accept, out_free, second;
  logic [COORD_W-1:0] src_x, src_y, xm, xp, z_m, z_p;
  logic               c_bank, cb;
  logic [BANK_AW-1:0] center0, center1, side0, side1;
  logic [BANK_AW-1:0] rd_addr0 [2];
  logic [BANK_AW-1:0] rd_addr1 [2];
  logic [ROW_W-1:0]   rd_data0 [2];
  logic [ROW_W-1:0]   rd_data1 [2];
  vfm_wr_t            wr [2];
  logic [ROW_W-1:0]   row_c, row_ym, row_xm, row_xp, row_mod;
  logic               inside_in, solid_eval;
  logic [5:0]         mask;
  logic [2:0]         count;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE) || ((state == S_QC) && out_free);
  assign accept   = in_valid && in_ready;

  assign inside_in = ({1'b0, pos_x} < EDGE_C) && ({1'b0, pos_y} < EDGE_C) &&
                     ({1'b0, pos_z} < EDGE_C);

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (clr_addr == BANK_AW'(BANK_ROWS - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (accept) state_next = (cmd == CMD_QUERY) ? S_QB : S_WR;
      end
      S_WR: state_next = S_IDLE;
      S_QB: state_next = S_QC;
      S_QC: begin
        if (out_free) begin
          if (accept) state_next = (cmd == CMD_QUERY) ? S_QB : S_WR;
          else state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) clr_addr <= clr_addr + 1'b1;
    end
  end

  // read address selection
  assign second = ((state == S_QB) || (state == S_QC)) && !accept;
  assign src_x  = accept ? pos_x : x_q;
  assign src_y  = accept ? pos_y : y_q;
  assign xm     = src_x - 1'b1;
  assign xp     = src_x + 1'b1;
  assign c_bank = src_x[0];

  assign center0 = second ? {x_q[COORD_W-1:1], COORD_W'(y_q + 1'b1)}
                          : {src_x[COORD_W-1:1], src_y};
  assign center1 = {src_x[COORD_W-1:1], COORD_W'(src_y - 1'b1)};
  assign side0   = {xm[COORD_W-1:1], src_y};
  assign side1   = {xp[COORD_W-1:1], src_y};

  always_comb begin
    for (int b = 0; b < 2; b++) begin
      if (c_bank == 1'(b)) begin
        rd_addr0[b] = center0;
        rd_addr1[b] = center1;
      end else begin
        rd_addr0[b] = side0;
        rd_addr1[b] = side1;
      end
    end
  end

  // row readout for the held request
  assign cb      = x_q[0];
  assign row_c   = rd_data0[cb];
  assign row_ym  = rd_data1[cb];
  assign row_xm  = rd_data0[~cb];
  assign row_xp  = rd_data1[~cb];
  assign z_m     = z_q - 1'b1;
  assign z_p     = z_q + 1'b1;
  assign nb_yp   = row_c[z_q];

  always_comb begin
    row_mod      = row_c;
    row_mod[z_q] = solid_q;
  end

  always_comb begin
    for (int b = 0; b < 2; b++) begin
      wr[b] = '0;
      if (state == S_CLEAR) begin
        wr[b].en   = 1'b1;
        wr[b].addr = clr_addr;
        wr[b].data = '0;
      end else if ((state == S_WR) && inside_q && (cb == 1'(b))) begin
        wr[b].en   = 1'b1;
        wr[b].addr = {x_q[COORD_W-1:1], y_q};
        wr[b].data = row_mod;
      end
    end
  end

  vfm_bank u_bank0 (
    .clk      (clk),
    .wr       (wr[0]),
    .rd_addr0 (rd_addr0[0]),
    .rd_addr1 (rd_addr1[0]),
    .rd_data0 (rd_data0[0]),
    .rd_data1 (rd_data1[0])
  );

  vfm_bank u_bank1 (
    .clk      (clk),
    .wr       (wr[1]),
    .rd_addr0 (rd_addr0[1]),
    .rd_addr1 (rd_addr1[1]),
    .rd_data0 (rd_data0[1]),
    .rd_data1 (rd_data1[1])
  );

  // hold request fields and first-read neighbor bits
  always_ff @(posedge clk) begin
    if (accept) begin
      x_q      <= pos_x;
      y_q      <= pos_y;
      z_q      <= pos_z;
      solid_q  <= solid_in;
      inside_q <= inside_in;
    end
    if (state == S_QB) begin
      solid_c <= row_c[z_q];
      nb_zm   <= row_c[z_m];
      nb_zp   <= row_c[z_p];
      nb_ym   <= row_ym[z_q];
      nb_xm   <= row_xm[z_q];
      nb_xp   <= row_xp[z_q];
    end
  end

  assign solid_eval = inside_q && solid_c;

  always_comb begin
    mask             = '0;
    mask[FACE_NEG_Z] = (z_q == '0)    || !nb_zm;
    mask[FACE_NEG_X] = (x_q == '0)    || !nb_xm;
    mask[FACE_POS_Z] = (z_q == LAST_C) || !nb_zp;
    mask[FACE_POS_X] = (x_q == LAST_C) || !nb_xp;
    mask[FACE_POS_Y] = (y_q == LAST_C) || !nb_yp;
    mask[FACE_NEG_Y] = (y_q == '0)    || !nb_ym;
    if (!solid_eval) mask = '0;
  end

  always_comb begin
    count = '0;
    for (int i = 0; i < 6; i++) begin
      count = count + 3'(mask[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_QC) && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_QC) && out_free) begin
      face_mask  <= mask;
      face_count <= count;
      cell_solid <= solid_eval;
    end
  end

`ifndef NO_ASSERTIONS
  a_query_seq: assert property (@(posedge clk) disable iff (rst)
    (accept && (cmd == CMD_QUERY)) |=> (state == S_QB))
    else $error("accepted query did not advance to second read");

  a_write_seq: assert property (@(posedge clk) disable iff (rst)
    (accept && (cmd == CMD_WRITE)) |=> (state == S_WR) && !in_ready)
    else $error("accepted write did not block for write back");

  a_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (face_count == 3'($countones(face_mask))))
    else $error("face count disagrees with face mask");

  a_empty: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !cell_solid) |-> (face_mask == '0))
    else $error("empty cell reported visible faces");

  a_no_wr_query: assert property (@(posedge clk) disable iff (rst)
    ((state == S_QB) || (state == S_QC)) |-> (!wr[0].en && !wr[1].en))
    else $error("bank write during query reads");
`endif

endmodule
